>>> hw/rtl/tpx_pkg.sv
// Shared types and constants of the two-plane XOR sprite display.
// Used by the plane bank and the top level; depends on nothing.

package tpx_pkg;

	// Pixel buffer geometry (power-of-two sizes)
	localparam int BUF_WIDTH      = 128;
	localparam int BUF_HEIGHT     = 64;
	localparam int PLANES_DEFAULT = 2;

	localparam int COL_W = $clog2(BUF_WIDTH);
	localparam int ROW_W = $clog2(BUF_HEIGHT);

	typedef logic [BUF_WIDTH-1:0] row_t;
	typedef logic [ROW_W-1:0]     row_addr_t;

	// Item function codes; 6 and 7 are unused
	typedef enum logic [2:0] {
		FUNC_CLEAR   = 3'd0,
		FUNC_SET_RES = 3'd1,
		FUNC_DRAW8   = 3'd2,
		FUNC_DRAW16  = 3'd3,
		FUNC_SCROLL  = 3'd4,
		FUNC_READ    = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		SCROLL_DOWN  = 2'd0,
		SCROLL_UP    = 2'd1,
		SCROLL_LEFT  = 2'd2,
		SCROLL_RIGHT = 2'd3
	} scroll_dir_t;

	// Row access control shared by all planes of the bank
	typedef struct packed {
		logic      rd_en;
		row_addr_t rd_row;
		row_addr_t wr_row;
	} bank_ctl_t;

endpackage

>>> hw/rtl/tpx_req_if.sv
// Input item channel of the sprite display: valid/ready plus the item fields.
// Stand-alone; no package needed.

interface tpx_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic        plane;
	logic [7:0]  pos_x;
	logic [7:0]  pos_y;
	logic [3:0]  row_index;
	logic [15:0] row_bits;
	logic        last_row;
	logic [6:0]  scroll_amount;
	logic [1:0]  scroll_dir;
	logic        high_res;

	modport source (
		output valid, func, plane, pos_x, pos_y, row_index, row_bits, last_row,
		       scroll_amount, scroll_dir, high_res,
		input  ready
	);

	modport sink (
		input  valid, func, plane, pos_x, pos_y, row_index, row_bits, last_row,
		       scroll_amount, scroll_dir, high_res,
		output ready
	);
endinterface

>>> hw/rtl/tpx_rsp_if.sv
// Result item channel of the sprite display: valid/ready plus collision and pixel bits.
// Stand-alone; no package needed.

interface tpx_rsp_if;
	logic       valid;
	logic       ready;
	logic       collision;
	logic [1:0] pixel_bits;

	modport source (output valid, collision, pixel_bits, input ready);
	modport sink (input valid, collision, pixel_bits, output ready);
endinterface

>>> hw/rtl/two_plane_xor_sprite_display_unit.sv
// Two-plane XOR sprite display: NUM_PLANES planes of 128x64 one-bit pixels, one RAM row per
// display row, with a high/low resolution flag. Depends on tpx_pkg, the channel interfaces
// and tpx_plane_bank. Every item returns exactly one result item. Draw, read, clear,
// set-resolution and unused codes are accepted in ST_IDLE, where a draw or read reads its row,
// and finish in ST_EXEC, where a draw XORs the row and writes it back. A scroll with a nonzero
// amount below the buffer size walks every row with one row read and one row write per cycle;
// a zero or oversize scroll finishes in ST_EXEC without the walk. The row RAM port pair sets
// this rate. Clears are instant (per-row valid bits), so no clearing pass follows reset. A
// finished result sits in an output register; if that register is still full, a second
// holding register takes the next result and the block waits there before accepting again.

module two_plane_xor_sprite_display_unit import tpx_pkg::*; #(
	parameter int NUM_PLANES = PLANES_DEFAULT
) (
	input logic            clk,
	input logic            arst_n,
	tpx_req_if.sink        req,
	tpx_rsp_if.source      rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_SCROLL_END,
		ST_RESULT
	} state_t;

	localparam logic [ROW_W:0] LH_HI    = (ROW_W+1)'(BUF_HEIGHT);
	localparam logic [ROW_W:0] LH_LO    = (ROW_W+1)'(BUF_HEIGHT / 2);
	localparam row_addr_t      LAST_ROW = ROW_W'(BUF_HEIGHT - 1);
	localparam logic [7:0]     H8       = 8'(BUF_HEIGHT);
	localparam logic [7:0]     HM1_8    = 8'(BUF_HEIGHT - 1);
	localparam row_t           LOW_MASK = {{(BUF_WIDTH - BUF_WIDTH/2){1'b0}},
	                                       {(BUF_WIDTH/2){1'b1}}};

	state_t      state_q;
	func_t       op_q;
	logic        high_res_q;
	logic        coll_acc_q;
	logic        rsp_valid_q;
	logic        rsp_coll_q;
	logic [1:0]  rsp_pix_q;
	logic        pend_coll_q;
	logic [1:0]  pend_pix_q;
	row_addr_t   cnt_q;
	logic        wv_s1;

	row_t        line_s1;
	logic        draw_ok_s1;
	row_addr_t   wrow_s1;
	logic        zero_s1;
	logic        plane_q;
	logic        last_q;
	logic [COL_W-1:0] rd_col_q;
	logic        rd_ok_q;
	logic [6:0]  amt_q;
	scroll_dir_t dir_q;

	logic        accept;
	func_t       req_func;
	logic        is_draw;
	logic [15:0] pat;
	logic [COL_W-1:0] sx;
	logic [ROW_W-1:0] y_base;
	logic [ROW_W:0]   sy;
	row_t        line;
	logic        row_in;
	logic        plane_ok;
	logic        rd_ok;
	logic        scroll_vert;
	logic        scroll_big;
	logic        scroll_walk;

	logic [7:0]  cnt8;
	logic [7:0]  amt8;
	logic [7:0]  tgt8;
	logic [7:0]  src8;
	logic        src_zero;

	bank_ctl_t             ctl;
	logic [NUM_PLANES-1:0] wr_en;
	logic [NUM_PLANES-1:0] clr;
	row_t [NUM_PLANES-1:0] wr_data;
	row_t [NUM_PLANES-1:0] rd_data;

	row_t        sel_row;
	logic        hit;
	logic        coll_now;
	logic        op_draw;
	logic        fin;
	logic        fin_coll;
	logic [1:0]  fin_pix;
	logic        slot_free;
	logic        rsp_load;

	assign req_func  = func_t'(req.func);
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_draw   = (req_func == FUNC_DRAW8) || (req_func == FUNC_DRAW16);

	// Build the sprite row pattern, column c at bit c, MSB leftmost on screen
	always_comb begin
		pat = '0;
		for (int c = 0; c < 16; c++) begin
			if (req_func == FUNC_DRAW16) begin
				pat[c] = req.row_bits[15-c];
			end else if (c < 8) begin
				pat[c] = req.row_bits[7-c];
			end
		end
	end

	// Wrap the start point to the logical screen and clip at its edges
	assign sx       = high_res_q ? req.pos_x[COL_W-1:0] : {1'b0, req.pos_x[COL_W-2:0]};
	assign y_base   = high_res_q ? req.pos_y[ROW_W-1:0] : {1'b0, req.pos_y[ROW_W-2:0]};
	assign sy       = {1'b0, y_base} + (ROW_W+1)'(req.row_index);
	assign row_in   = high_res_q ? (sy < LH_HI) : (sy < LH_LO);
	assign line     = (row_t'(pat) << sx) & (high_res_q ? {BUF_WIDTH{1'b1}} : LOW_MASK);
	assign plane_ok = int'(req.plane) < NUM_PLANES;
	assign rd_ok    = (int'(req.pos_x) < BUF_WIDTH) && (int'(req.pos_y) < BUF_HEIGHT);

	// Classify the scroll: nothing, clear everything, or walk all rows
	assign scroll_vert = (req.scroll_dir == SCROLL_DOWN) || (req.scroll_dir == SCROLL_UP);
	assign scroll_big  = scroll_vert ? (int'(req.scroll_amount) >= BUF_HEIGHT)
	                                 : (int'(req.scroll_amount) >= BUF_WIDTH);
	assign scroll_walk = (req_func == FUNC_SCROLL) && (req.scroll_amount != '0) && !scroll_big;

	// Scroll walk: target row and its source row for this step
	assign cnt8 = 8'(cnt_q);
	assign amt8 = {1'b0, amt_q};

	always_comb begin
		case (dir_q)
			SCROLL_DOWN: begin
				tgt8     = HM1_8 - cnt8;
				src8     = tgt8 - amt8;
				src_zero = tgt8 < amt8;
			end
			SCROLL_UP: begin
				tgt8     = cnt8;
				src8     = cnt8 + amt8;
				src_zero = src8 >= H8;
			end
			default: begin
				tgt8     = cnt8;
				src8     = cnt8;
				src_zero = 1'b0;
			end
		endcase
	end

	// Row read/write addressing
	always_comb begin
		ctl.rd_en  = (accept && (is_draw || (req_func == FUNC_READ))) || (state_q == ST_SCROLL);
		ctl.wr_row = wrow_s1;
		if (state_q == ST_SCROLL) begin
			ctl.rd_row = src8[ROW_W-1:0];
		end else if (is_draw) begin
			ctl.rd_row = sy[ROW_W-1:0];
		end else begin
			ctl.rd_row = req.pos_y[ROW_W-1:0];
		end
	end

	assign op_draw = (op_q == FUNC_DRAW8) || (op_q == FUNC_DRAW16);

	// Per-plane clears, write enables and write data
	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			clr[p] = accept && (((req_func == FUNC_CLEAR) && (int'(req.plane) == p))
			         || (req_func == FUNC_SET_RES)
			         || ((req_func == FUNC_SCROLL) && (req.scroll_amount != '0) && scroll_big));
			if ((state_q == ST_SCROLL && wv_s1) || state_q == ST_SCROLL_END) begin
				wr_en[p] = 1'b1;
				if (zero_s1) begin
					wr_data[p] = '0;
				end else if (dir_q == SCROLL_LEFT) begin
					wr_data[p] = rd_data[p] >> amt_q;
				end else if (dir_q == SCROLL_RIGHT) begin
					wr_data[p] = rd_data[p] << amt_q;
				end else begin
					wr_data[p] = rd_data[p];
				end
			end else begin
				wr_en[p]   = (state_q == ST_EXEC) && op_draw && draw_ok_s1
				             && (int'(plane_q) == p);
				wr_data[p] = rd_data[p] ^ line_s1;
			end
		end
	end

	tpx_plane_bank #(
		.NUM_PLANES (NUM_PLANES)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_en   (wr_en),
		.clr     (clr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// Collision and read result of the finishing item
	always_comb begin
		sel_row = '0;
		fin_pix = '0;
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (int'(plane_q) == p) begin
				sel_row = rd_data[p];
			end
			fin_pix[p] = (op_q == FUNC_READ) && rd_ok_q && rd_data[p][rd_col_q];
		end
	end

	assign hit       = draw_ok_s1 && (|(sel_row & line_s1));
	assign coll_now  = coll_acc_q | hit;
	assign fin_coll  = op_draw && coll_now;
	assign fin       = (state_q == ST_EXEC) || (state_q == ST_SCROLL_END);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rsp_load  = slot_free && (fin || (state_q == ST_RESULT));

	// Control state, sequencing and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= FUNC_CLEAR;
			high_res_q  <= 1'b0;
			coll_acc_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_coll_q  <= 1'b0;
			rsp_pix_q   <= '0;
			pend_coll_q <= 1'b0;
			pend_pix_q  <= '0;
			cnt_q       <= '0;
			wv_s1       <= 1'b0;
		end else begin
			// Drop the taken result unless a new one loads at this edge
			if (rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= req_func;
						cnt_q <= '0;
						wv_s1 <= 1'b0;
						if (req_func == FUNC_SET_RES) begin
							high_res_q <= req.high_res;
						end
						state_q <= scroll_walk ? ST_SCROLL : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op_draw) begin
						coll_acc_q <= last_q ? 1'b0 : coll_now;
					end
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					wv_s1 <= 1'b1;
					if (cnt_q == LAST_ROW) begin
						state_q <= ST_SCROLL_END;
					end
				end
				ST_SCROLL_END: begin
					wv_s1 <= 1'b0;
				end
				ST_RESULT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						rsp_coll_q  <= pend_coll_q;
						rsp_pix_q   <= pend_pix_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Hand the result over, or park it until the output frees up
			if (fin) begin
				if (slot_free) begin
					rsp_valid_q <= 1'b1;
					rsp_coll_q  <= fin_coll;
					rsp_pix_q   <= fin_pix;
					state_q     <= ST_IDLE;
				end else begin
					pend_coll_q <= fin_coll;
					pend_pix_q  <= fin_pix;
					state_q     <= ST_RESULT;
				end
			end
		end
	end

	// Item payload and scroll pipeline stage
	always_ff @(posedge clk) begin
		if (accept) begin
			line_s1    <= line;
			draw_ok_s1 <= plane_ok && row_in;
			wrow_s1    <= sy[ROW_W-1:0];
			zero_s1    <= 1'b0;
			plane_q    <= req.plane;
			last_q     <= req.last_row;
			rd_col_q   <= req.pos_x[COL_W-1:0];
			rd_ok_q    <= rd_ok;
			amt_q      <= req.scroll_amount;
			dir_q      <= scroll_dir_t'(req.scroll_dir);
		end else if (state_q == ST_SCROLL) begin
			wrow_s1 <= tgt8[ROW_W-1:0];
			zero_s1 <= src_zero;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.collision  = rsp_coll_q;
	assign rsp.pixel_bits = rsp_pix_q;

endmodule

>>> hw/rtl/tpx_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.

module tpx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/tpx_plane_bank.sv
// Pixel plane bank: one row-wide RAM per plane plus a valid bit per row.
// Depends on tpx_pkg and tpx_ram. A row never written since reset or clear reads as zero.

module tpx_plane_bank import tpx_pkg::*; #(
	parameter int NUM_PLANES = PLANES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bank_ctl_t             ctl,
	input  logic [NUM_PLANES-1:0] wr_en,
	input  logic [NUM_PLANES-1:0] clr,
	input  row_t [NUM_PLANES-1:0] wr_data,
	output row_t [NUM_PLANES-1:0] rd_data
);

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		logic [BUF_HEIGHT-1:0] vld_q;
		logic                  vld_s1;
		row_t                  ram_rd;

		tpx_ram #(
			.WIDTH (BUF_WIDTH),
			.DEPTH (BUF_HEIGHT)
		) u_ram (
			.clk     (clk),
			.wr_en   (wr_en[p]),
			.wr_addr (ctl.wr_row),
			.wr_data (wr_data[p]),
			.rd_en   (ctl.rd_en),
			.rd_addr (ctl.rd_row),
			.rd_data (ram_rd)
		);

		// Mark written rows; drop all marks on a plane clear
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= '0;
			end else if (clr[p]) begin
				vld_q <= '0;
			end else if (wr_en[p]) begin
				vld_q[ctl.wr_row] <= 1'b1;
			end
		end

		// Sample the row mark alongside the RAM read
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
			end else if (ctl.rd_en) begin
				vld_s1 <= vld_q[ctl.rd_row];
			end
		end

		assign rd_data[p] = vld_s1 ? ram_rd : '0;
	end

endmodule

>>> tb/sv/tpx_display_check.sv
// Self-checking monitor for the two-plane XOR sprite display: keeps its own picture of the planes.
// Watches both item channels, predicts each result and compares it field by field.
// Depends on tpx_pkg and the channel interfaces tpx_req_if and tpx_rsp_if.

module tpx_display_check import tpx_pkg::*; #(
	parameter int NUM_PLANES = PLANES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	tpx_req_if   req,
	tpx_rsp_if   rsp,
	output int   fail_count,
	output int   open_count,
	output int   done_count
);

	typedef struct packed {
		logic       collision;
		logic [1:0] pixel_bits;
	} disp_result_t;

	// Shadow copy of the pixel planes, one packed row per display row; bit x is column x
	row_t         plane_rows [NUM_PLANES][BUF_HEIGHT];
	logic         hires;
	logic         coll_sticky;
	disp_result_t result_q[$];
	disp_result_t want;
	disp_result_t fresh;

	task automatic blank_plane(input int p);
		for (int r = 0; r < BUF_HEIGHT; r++)
			plane_rows[p][r] = '0;
	endtask

	// Shift every plane over the full buffer, filling with zeros
	task automatic shift_planes(input int n, input scroll_dir_t dir);
		if (n == 0)
			return;
		for (int p = 0; p < NUM_PLANES; p++) begin
			case (dir)
				SCROLL_DOWN: begin
					if (n >= BUF_HEIGHT)
						blank_plane(p);
					else
						for (int r = BUF_HEIGHT - 1; r >= 0; r--) begin
							if (r >= n)
								plane_rows[p][r] = plane_rows[p][r - n];
							else
								plane_rows[p][r] = '0;
						end
				end
				SCROLL_UP: begin
					if (n >= BUF_HEIGHT)
						blank_plane(p);
					else
						for (int r = 0; r < BUF_HEIGHT; r++) begin
							if (r + n < BUF_HEIGHT)
								plane_rows[p][r] = plane_rows[p][r + n];
							else
								plane_rows[p][r] = '0;
						end
				end
				SCROLL_LEFT: begin
					if (n >= BUF_WIDTH)
						blank_plane(p);
					else
						for (int r = 0; r < BUF_HEIGHT; r++)
							plane_rows[p][r] = plane_rows[p][r] >> n;
				end
				default: begin
					if (n >= BUF_WIDTH)
						blank_plane(p);
					else
						for (int r = 0; r < BUF_HEIGHT; r++)
							plane_rows[p][r] = plane_rows[p][r] << n;
				end
			endcase
		end
	endtask

	// XOR one sprite row into a plane; wrap the start point, clip at the logical edges
	task automatic xor_sprite_row(input int p, input int span, input logic [15:0] bits,
	                              output logic hit);
		int lw;
		int lh;
		int sx;
		int sy;
		hit = 1'b0;
		lw = hires ? BUF_WIDTH : BUF_WIDTH / 2;
		lh = hires ? BUF_HEIGHT : BUF_HEIGHT / 2;
		sx = int'(req.pos_x) % lw;
		sy = int'(req.pos_y) % lh + int'(req.row_index);
		if (p >= NUM_PLANES || sy >= lh)
			return;
		for (int c = 0; c < span; c++) begin
			if (sx + c < lw && bits[span - 1 - c]) begin
				if (plane_rows[p][sy][sx + c])
					hit = 1'b1;
				plane_rows[p][sy][sx + c] = ~plane_rows[p][sy][sx + c];
			end
		end
	endtask

	// Apply the accepted item to the shadow state and work out its result
	task automatic predict_display(output disp_result_t res);
		logic hit;
		res = '0;
		case (req.func)
			FUNC_CLEAR: begin
				if (int'(req.plane) < NUM_PLANES)
					blank_plane(int'(req.plane));
			end
			FUNC_SET_RES: begin
				hires = req.high_res;
				for (int p = 0; p < NUM_PLANES; p++)
					blank_plane(p);
			end
			FUNC_DRAW8, FUNC_DRAW16: begin
				if (req.func == FUNC_DRAW16)
					xor_sprite_row(int'(req.plane), 16, req.row_bits, hit);
				else
					xor_sprite_row(int'(req.plane), 8, {8'h00, req.row_bits[7:0]}, hit);
				if (hit)
					coll_sticky = 1'b1;
				res.collision = coll_sticky;
				if (req.last_row)
					coll_sticky = 1'b0;
			end
			FUNC_SCROLL: begin
				shift_planes(int'(req.scroll_amount), scroll_dir_t'(req.scroll_dir));
			end
			FUNC_READ: begin
				if (int'(req.pos_x) < BUF_WIDTH && int'(req.pos_y) < BUF_HEIGHT)
					for (int p = 0; p < NUM_PLANES; p++)
						res.pixel_bits[p] = plane_rows[p][req.pos_y][req.pos_x];
			end
			default: ;
		endcase
	endtask

	// Check results first, then queue the prediction for an item taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++)
				blank_plane(p);
			hires       = 1'b0;
			coll_sticky = 1'b0;
			result_q.delete();
			fail_count  = 0;
			open_count  = 0;
			done_count  = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with none pending, collision %0b pixel_bits %0d",
					         $time, rsp.collision, rsp.pixel_bits);
				end else begin
					want = result_q.pop_front();
					done_count++;
					if (rsp.collision !== want.collision) begin
						fail_count++;
						$display("%0t: collision mismatch, expected %0b, actual %0b",
						         $time, want.collision, rsp.collision);
					end
					if (rsp.pixel_bits !== want.pixel_bits) begin
						fail_count++;
						$display("%0t: pixel_bits mismatch, expected %0d, actual %0d",
						         $time, want.pixel_bits, rsp.pixel_bits);
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_display(fresh);
				result_q.push_back(fresh);
			end
			open_count = result_q.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// Top of the sprite display testbench: clock, reset, item stimulus, output stalls and verdict.
// Depends on tpx_pkg, tpx_req_if, tpx_rsp_if, the display unit and tpx_display_check.

module tb;
	import tpx_pkg::*;

	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         ITEM_TOTAL   = 1980;
	localparam int         CALM_ITEMS   = 300;
	localparam int         HOLD_AT      = 600;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_CYCLES = 80;
	localparam logic [2:0] FUNC_SPARE6  = 3'd6;
	localparam logic [2:0] FUNC_SPARE7  = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic        plane;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [3:0]  row_index;
		logic [15:0] row_bits;
		logic        last_row;
		logic [6:0]  scroll_amount;
		logic [1:0]  scroll_dir;
		logic        high_res;
	} disp_item_t;

	logic clk;
	logic arst_n;
	logic idle_on;
	logic hold_req;
	int   fail_count;
	int   open_count;
	int   done_count;
	int   n_sent;
	int   func_count [8];

	tpx_req_if req_ch ();
	tpx_rsp_if rsp_ch ();

	two_plane_xor_sprite_display_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tpx_display_check display_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.open_count (open_count),
		.done_count (done_count)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up after the cycle limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: errors");
		$finish;
	end

	// Drive result ready: random short stalls, one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Fill every field at random, then set the function
	function automatic disp_item_t base_item(input logic [2:0] f);
		logic [63:0] r;
		disp_item_t  it;
		r       = {$urandom, $urandom};
		it      = r[$bits(disp_item_t)-1:0];
		it.func = f;
		return it;
	endfunction

	// Offer one item at the falling edge and hold it until accepted
	task automatic send(input disp_item_t it);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_ch.func          <= it.func;
		req_ch.plane         <= it.plane;
		req_ch.pos_x         <= it.pos_x;
		req_ch.pos_y         <= it.pos_y;
		req_ch.row_index     <= it.row_index;
		req_ch.row_bits      <= it.row_bits;
		req_ch.last_row      <= it.last_row;
		req_ch.scroll_amount <= it.scroll_amount;
		req_ch.scroll_dir    <= it.scroll_dir;
		req_ch.high_res      <= it.high_res;
		req_ch.valid         <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		n_sent++;
		func_count[it.func]++;
	endtask

	task automatic send_draw(input logic [2:0] f, input logic p, input logic [7:0] x,
	                         input logic [7:0] y, input logic [3:0] idx,
	                         input logic [15:0] bits, input logic last);
		disp_item_t it;
		it           = base_item(f);
		it.plane     = p;
		it.pos_x     = x;
		it.pos_y     = y;
		it.row_index = idx;
		it.row_bits  = bits;
		it.last_row  = last;
		send(it);
	endtask

	task automatic send_read(input logic [7:0] x, input logic [7:0] y);
		disp_item_t it;
		it       = base_item(FUNC_READ);
		it.pos_x = x;
		it.pos_y = y;
		send(it);
	endtask

	task automatic send_scroll(input logic [6:0] amt, input scroll_dir_t dir);
		disp_item_t it;
		it               = base_item(FUNC_SCROLL);
		it.scroll_amount = amt;
		it.scroll_dir    = dir;
		send(it);
	endtask

	task automatic send_clear(input logic p);
		disp_item_t it;
		it       = base_item(FUNC_CLEAR);
		it.plane = p;
		send(it);
	endtask

	task automatic send_res(input logic h);
		disp_item_t it;
		it          = base_item(FUNC_SET_RES);
		it.high_res = h;
		send(it);
	endtask

	initial begin
		int          pick;
		int          rows;
		logic [2:0]  df;
		logic        dp;
		logic [7:0]  sx;
		logic [7:0]  sy;
		logic [3:0]  idx;
		logic [6:0]  amt;
		logic        hold_done;

		req_ch.valid         = 1'b0;
		req_ch.func          = FUNC_CLEAR;
		req_ch.plane         = 1'b0;
		req_ch.pos_x         = '0;
		req_ch.pos_y         = '0;
		req_ch.row_index     = '0;
		req_ch.row_bits      = '0;
		req_ch.last_row      = 1'b0;
		req_ch.scroll_amount = '0;
		req_ch.scroll_dir    = SCROLL_DOWN;
		req_ch.high_res      = 1'b0;
		arst_n    = 1'b0;
		idle_on   = 1'b0;
		hold_req  = 1'b0;
		hold_done = 1'b0;
		n_sent    = 0;
		sx        = '0;
		sy        = '0;
		foreach (func_count[i])
			func_count[i] = 0;

		// Hold reset, then release it between edges
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty read, high res, clipping at right and bottom, row off screen
		send_read(8'd0, 8'd0);
		send_res(1'b1);
		send_draw(FUNC_DRAW16, 1'b0, 8'd120, 8'd60, 4'd0, 16'hFFFF, 1'b0);
		send_draw(FUNC_DRAW16, 1'b0, 8'd120, 8'd60, 4'd3, 16'h8001, 1'b0);
		send_draw(FUNC_DRAW16, 1'b0, 8'd120, 8'd60, 4'd15, 16'hFFFF, 1'b1);
		// Collision on a one-row sprite, then wrapped start with the draw-8 byte
		send_draw(FUNC_DRAW16, 1'b0, 8'd120, 8'd60, 4'd0, 16'h8000, 1'b1);
		send_draw(FUNC_DRAW8, 1'b1, 8'd255, 8'd255, 4'd0, 16'hFF00, 1'b0);
		send_draw(FUNC_DRAW8, 1'b1, 8'd255, 8'd255, 4'd0, 16'h0080, 1'b1);
		send_read(8'd127, 8'd63);
		send_read(8'd121, 8'd60);
		// Reads outside the buffer
		send_read(8'd255, 8'd255);
		send_read(8'd128, 8'd0);
		// Scroll: zero, one pixel each way, edge amounts and oversize
		send_scroll(7'd0, SCROLL_DOWN);
		send_scroll(7'd1, SCROLL_UP);
		send_scroll(7'd1, SCROLL_LEFT);
		send_scroll(7'd1, SCROLL_RIGHT);
		send_scroll(7'd63, SCROLL_DOWN);
		send_scroll(7'd64, SCROLL_UP);
		send_scroll(7'd127, SCROLL_LEFT);
		send_clear(1'b0);
		send_clear(1'b1);
		// Low resolution: clip at 64 columns, then collide on the same spot
		send_res(1'b0);
		send_draw(FUNC_DRAW16, 1'b1, 8'd62, 8'd31, 4'd0, 16'hFFFF, 1'b1);
		send_draw(FUNC_DRAW16, 1'b1, 8'd62, 8'd31, 4'd0, 16'hC000, 1'b1);
		send_read(8'd63, 8'd31);
		send(base_item(FUNC_SPARE6));
		send(base_item(FUNC_SPARE7));

		// Random: mostly sprites with nearby reads, some scrolls, clears and noise
		idle_on = 1'b1;
		while (n_sent < ITEM_TOTAL) begin
			if (n_sent >= ITEM_TOTAL - CALM_ITEMS)
				idle_on = 1'b0;
			if (!hold_done && n_sent >= HOLD_AT) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				rows = $urandom_range(1, 16);
				df   = $urandom_range(0, 1) ? FUNC_DRAW16 : FUNC_DRAW8;
				dp   = 1'($urandom_range(0, 1));
				sx   = 8'($urandom_range(0, 255));
				sy   = 8'($urandom_range(0, 255));
				for (int i = 0; i < rows; i++) begin
					idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'(i);
					send_draw(df, dp, sx, sy, idx, 16'($urandom), i == rows - 1);
				end
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1))
						send_read(8'((sx % 128) + $urandom_range(0, 15)),
						          8'((sy % 64) + $urandom_range(0, 15)));
					else
						send_read(8'($urandom_range(0, 159)), 8'($urandom_range(0, 79)));
				end
			end else if (pick < 87) begin
				case ($urandom_range(0, 9))
					0:       amt = 7'd0;
					1, 2:    amt = 7'($urandom_range(0, 127));
					default: amt = 7'($urandom_range(1, 8));
				endcase
				send_scroll(amt, scroll_dir_t'($urandom_range(0, 3)));
			end else if (pick < 90) begin
				send_clear(1'($urandom_range(0, 1)));
			end else if (pick < 91) begin
				send_res(1'($urandom_range(0, 1)));
			end else begin
				send(base_item(3'($urandom_range(0, 7))));
			end
		end

		// Drop valid, drain every pending result, then let the pipe settle
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (open_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d items (%0d draws, %0d reads, %0d scrolls, %0d clears, %0d res)",
		         n_sent, func_count[FUNC_DRAW8] + func_count[FUNC_DRAW16],
		         func_count[FUNC_READ], func_count[FUNC_SCROLL], func_count[FUNC_CLEAR],
		         func_count[FUNC_SET_RES]);
		$display("summary: %0d results compared, with one long output hold-off of %0d cycles",
		         done_count, HOLD_CYCLES);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/tpx_pkg.sv
hw/rtl/tpx_req_if.sv
hw/rtl/tpx_rsp_if.sv
hw/rtl/tpx_ram.sv
hw/rtl/tpx_plane_bank.sv
hw/rtl/two_plane_xor_sprite_display_unit.sv
tb/sv/tpx_display_check.sv
tb/sv/tb.sv
